@@ rtl/ttpm_pkg.sv @@
// Shared types, register codes and helpers for the three-timer module.
package ttpm_pkg;

   // Item kinds on the request channel
   typedef enum logic [2:0] {
      KIND_READ   = 3'd0,
      KIND_WRITE  = 3'd1,
      KIND_TICK   = 3'd2,
      KIND_PULSE1 = 3'd3,
      KIND_PULSE2 = 3'd4
   } ttpm_kind_type;

   // Register offsets with a fixed meaning
   localparam logic [2:0] OFS_CTRL13  = 3'd0;
   localparam logic [2:0] OFS_CTRL2   = 3'd1;
   localparam logic [2:0] OFS_STATUS  = 3'd1;

   // Control and status bit masks
   localparam logic [7:0]  IRQ_ENABLE_MASK = 8'h40;
   localparam logic [7:0]  IRQ_FLAG_MASK   = 8'h80;
   localparam logic [7:0]  MODE_MASK       = 8'h38;
   localparam logic [7:0]  HOLD_LOAD_MASK  = 8'h10;
   localparam logic [15:0] COUNT_ALL_ONES  = 16'hFFFF;
   localparam int          NUM_TIMERS      = 3;

   // One accepted request
   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] offset;
      logic [7:0] write_data;
   } ttpm_item_type;

   // One result
   typedef struct packed {
      logic [7:0] read_data;
      logic       irq;
      logic [2:0] done;
   } ttpm_result_type;

   // Composite interrupt: bit 7 set when any flag 0..2 meets its enable
   function automatic logic [7:0] ttpm_irq_update(input logic [7:0] status,
                                                  input logic [2:0] enables);
      logic [7:0] result;
      result    = status;
      result[7] = |(status[2:0] & enables);
      return result;
   endfunction

endpackage

@@ rtl/ttpm_if.sv @@
// Valid/ready channel interfaces for requests and results.
interface ttpm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [2:0] offset;
   logic [7:0] write_data;

   modport source (output valid, output kind, output offset, output write_data,
                   input ready);
   modport sink   (input valid, input kind, input offset, input write_data,
                   output ready);
endinterface

interface ttpm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       irq;
   logic       timer1_done;
   logic       timer2_done;
   logic       timer3_done;

   modport source (output valid, output read_data, output irq, output timer1_done,
                   output timer2_done, output timer3_done, input ready);
   modport sink   (input valid, input read_data, input irq, input timer1_done,
                   input timer2_done, input timer3_done, output ready);
endinterface

@@ rtl/three_timer_programmable_module_core.sv @@
// Three-timer module top level: request register, timer core, result register.
//
// Usage:
//   req_bus carries one item per transfer: kind (read, write, internal tick,
//   timer 1 or timer 2 external pulse), register offset and write byte.
//   rsp_bus returns exactly one result per item, in order: the read byte
//   (zero for non-reads and offset 0), the interrupt flag after the item,
//   and one done bit per timer that timed out on this item.
//   Each item passes through the request register; the timer update then
//   loads its result into the result register, which drives rsp_bus.
//   Throughput is one item per cycle while the receiver keeps taking results;
//   the timer state update between the request and result registers is a
//   single pass, so a tick or bus access can be taken every clock.
//   When the receiver stalls, the result register holds its item and the
//   request register can still take one more item; after that req ready
//   drops until the result is taken.
//   Synchronous reset empties both registers, loads latches and counters
//   with all ones, control 1 with 1, and clears the other registers.
module three_timer_programmable_module_core
   import ttpm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ttpm_req_if.sink  req_bus,
   ttpm_rsp_if.source rsp_bus
);

   logic            in_valid_ff, in_valid_in;
   ttpm_item_type   item_ff, item_in;
   logic            out_valid_ff, out_valid_in;
   ttpm_result_type result_ff, result_in;
   ttpm_result_type core_result;
   logic            advance;
   logic            req_xfer;

   // Pipeline flow control
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_xfer      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      item_in      = item_ff;
      out_valid_in = out_valid_ff;
      result_in    = result_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
         item_in     = '{kind: req_bus.kind, offset: req_bus.offset,
                         write_data: req_bus.write_data};
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         result_in    = core_result;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   ttpm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .exec   (advance),
      .item   (item_ff),
      .result (core_result)
   );

   // Request and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.read_data   = result_ff.read_data;
   assign rsp_bus.irq         = result_ff.irq;
   assign rsp_bus.timer1_done = result_ff.done[0];
   assign rsp_bus.timer2_done = result_ff.done[1];
   assign rsp_bus.timer3_done = result_ff.done[2];

endmodule

@@ rtl/ttpm_core.sv @@
// Timer state registers and the single-pass update for one item.
module ttpm_core
   import ttpm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            exec,
   input  ttpm_item_type   item,
   output ttpm_result_type result
);

   logic [15:0] latch_ff [NUM_TIMERS];
   logic [15:0] latch_in [NUM_TIMERS];
   logic [15:0] count_ff [NUM_TIMERS];
   logic [15:0] count_in [NUM_TIMERS];
   logic [7:0]  ctrl_ff  [NUM_TIMERS];
   logic [7:0]  ctrl_in  [NUM_TIMERS];
   logic [7:0]  status_ff, status_in;
   logic [7:0]  seen_ff, seen_in;
   logic [7:0]  msb_buf_ff, msb_buf_in;
   logic [2:0]  div_ff, div_in;

   logic [7:0]  rd_data;
   logic [2:0]  done;
   logic [1:0]  tsel;
   logic [1:0]  psel;
   logic        run;
   logic        step;

   // Next-state logic for the item being executed
   always_comb begin
      latch_in   = latch_ff;
      count_in   = count_ff;
      ctrl_in    = ctrl_ff;
      status_in  = status_ff;
      seen_in    = seen_ff;
      msb_buf_in = msb_buf_ff;
      div_in     = div_ff;
      rd_data    = '0;
      done       = '0;
      run        = 1'b0;
      step       = 1'b0;
      psel       = 2'd0;
      // offsets 2..7 map to timers 0..2
      tsel       = item.offset[2:1] - 2'd1;

      if (exec) begin
         case (ttpm_kind_type'(item.kind))
            KIND_READ: begin
               if (item.offset == OFS_CTRL13) begin
                  rd_data = '0;
               end else if (item.offset == OFS_STATUS) begin
                  seen_in = status_ff;
                  rd_data = status_ff;
               end else if (!item.offset[0]) begin
                  // MSB read after status read acknowledges the flag
                  if (seen_ff[tsel]) begin
                     status_in[tsel] = 1'b0;
                     status_in = ttpm_irq_update(status_in,
                        {ctrl_ff[2][6], ctrl_ff[1][6], ctrl_ff[0][6]});
                  end
                  seen_in[tsel] = 1'b0;
                  rd_data = latch_ff[tsel][15:8];
               end else begin
                  rd_data = latch_ff[tsel][7:0];
               end
            end
            KIND_WRITE: begin
               if (item.offset == OFS_CTRL13) begin
                  if (ctrl_ff[1][0]) begin
                     ctrl_in[0] = item.write_data;
                  end else begin
                     ctrl_in[2] = item.write_data;
                  end
                  status_in = ttpm_irq_update(status_in,
                     {ctrl_in[2][6], ctrl_in[1][6], ctrl_in[0][6]});
                  if (ctrl_ff[1][0] && item.write_data[0]) begin
                     status_in = '0;
                  end
               end else if (item.offset == OFS_CTRL2) begin
                  ctrl_in[1] = item.write_data;
                  status_in = ttpm_irq_update(status_in,
                     {ctrl_in[2][6], ctrl_in[1][6], ctrl_in[0][6]});
               end else if (!item.offset[0]) begin
                  msb_buf_in = item.write_data;
               end else begin
                  latch_in[tsel] = {msb_buf_ff, item.write_data};
                  if ((ctrl_ff[tsel] & HOLD_LOAD_MASK) == '0) begin
                     count_in[tsel] = {msb_buf_ff, item.write_data};
                  end
                  status_in[tsel] = 1'b0;
                  status_in = ttpm_irq_update(status_in,
                     {ctrl_ff[2][6], ctrl_ff[1][6], ctrl_ff[0][6]});
               end
            end
            KIND_TICK: begin
               if (!ctrl_ff[0][0]) begin
                  for (int i = 0; i < NUM_TIMERS; i++) begin
                     if (ctrl_ff[i][1] && !ctrl_ff[i][3]) begin
                        step = 1'b1;
                        // timeout: flag and reload; timer 3 counts on
                        if (count_ff[i] == '0) begin
                           done[i]      = 1'b1;
                           status_in[i] = 1'b1;
                           if ((ctrl_ff[i] & IRQ_ENABLE_MASK) != '0) begin
                              status_in[7] = 1'b1;
                           end
                           count_in[i] = latch_ff[i];
                           step        = (i == NUM_TIMERS - 1);
                        end
                        // timer 3 optional divide by 8
                        if (step && (i == NUM_TIMERS - 1) && ctrl_ff[i][0]) begin
                           div_in = div_ff + 3'd1;
                           step   = (div_in == '0);
                        end
                        if (step) begin
                           count_in[i] = count_in[i] - 16'd1;
                        end
                     end
                  end
               end
            end
            KIND_PULSE1, KIND_PULSE2: begin
               if (ttpm_kind_type'(item.kind) == KIND_PULSE1) begin
                  psel = 2'd0;
                  run  = !(ctrl_ff[0][0] && ctrl_ff[0][1]);
               end else begin
                  psel = 2'd1;
                  run  = !ctrl_ff[0][0] && !ctrl_ff[1][1];
               end
               // external count stops at zero
               if (run && count_ff[psel] != '0) begin
                  count_in[psel] = count_ff[psel] - 16'd1;
                  if (count_in[psel] == '0) begin
                     done[psel]      = 1'b1;
                     status_in[psel] = 1'b1;
                     if ((ctrl_ff[psel] & IRQ_ENABLE_MASK) != '0) begin
                        status_in[7] = 1'b1;
                        seen_in      = seen_ff & ~status_in;
                     end
                     if (psel == 2'd0 || (ctrl_ff[1] & MODE_MASK) == '0) begin
                        count_in[psel] = latch_ff[psel];
                     end
                  end
               end
            end
            default: begin
               rd_data = '0;
            end
         endcase
      end
   end

   assign result.read_data = rd_data;
   assign result.irq       = status_in[7];
   assign result.done      = done;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         // control 1 starts with bit 0 set, the others clear
         for (int i = 0; i < NUM_TIMERS; i++) begin
            latch_ff[i] <= COUNT_ALL_ONES;
            count_ff[i] <= COUNT_ALL_ONES;
            ctrl_ff[i]  <= (i == 0) ? 8'h01 : 8'h00;
         end
         status_ff  <= '0;
         seen_ff    <= '0;
         msb_buf_ff <= '0;
         div_ff     <= '0;
      end else begin
         latch_ff   <= latch_in;
         count_ff   <= count_in;
         ctrl_ff    <= ctrl_in;
         status_ff  <= status_in;
         seen_ff    <= seen_in;
         msb_buf_ff <= msb_buf_in;
         div_ff     <= div_in;
      end
   end

endmodule

@@ bench/ttpm_tb_pkg.sv @@
`timescale 1ns / 100ps
// Scoreboard class for the three-timer module: timer model and in-order result check.
package ttpm_tb_pkg;
   import ttpm_pkg::*;

   class timer_scoreboard;
      // model state
      logic [15:0] latch_q [NUM_TIMERS];
      logic [15:0] count_q [NUM_TIMERS];
      logic [7:0]  ctrl_q [NUM_TIMERS];
      logic [7:0]  status_q;
      logic [7:0]  seen_q;
      logic [7:0]  msb_buf_q;
      logic [2:0]  prescale_q;

      // results owed by the block, oldest first
      ttpm_result_type awaited_results [$];
      int error_count;

      function new();
         int t;
         for (t = 0; t < NUM_TIMERS; t++) begin
            latch_q[t] = COUNT_ALL_ONES;
            count_q[t] = COUNT_ALL_ONES;
            ctrl_q[t]  = 8'h00;
         end
         ctrl_q[0]   = 8'h01;
         status_q    = 8'h00;
         seen_q      = 8'h00;
         msb_buf_q   = 8'h00;
         prescale_q  = 3'd0;
         error_count = 0;
      endfunction

      // bit 7 set when some flag meets its enable
      function void refresh_irq();
         int t;
         logic any;
         any = 1'b0;
         for (t = 0; t < NUM_TIMERS; t++)
            if (status_q[t] && (ctrl_q[t] & IRQ_ENABLE_MASK) != 8'h00)
               any = 1'b1;
         status_q[7] = any;
      endfunction

      function logic [7:0] bus_read(logic [2:0] offset);
         int t;
         t = (int'(offset) - 2) / 2;
         if (offset == OFS_CTRL13)
            return 8'h00;
         if (offset == OFS_STATUS) begin
            seen_q = status_q;
            return status_q;
         end
         if (!offset[0]) begin
            // MSB read after a status read acknowledges the flag
            if (seen_q[t]) begin
               status_q[t] = 1'b0;
               refresh_irq();
            end
            seen_q[t] = 1'b0;
            return latch_q[t][15:8];
         end
         return latch_q[t][7:0];
      endfunction

      function void bus_write(logic [2:0] offset, logic [7:0] data);
         int t;
         t = (int'(offset) - 3) / 2;
         if (offset == OFS_CTRL13) begin
            if (ctrl_q[1][0]) begin
               ctrl_q[0] = data;
               refresh_irq();
               if (data[0])
                  status_q = 8'h00;
            end else begin
               ctrl_q[2] = data;
               refresh_irq();
            end
         end else if (offset == OFS_CTRL2) begin
            ctrl_q[1] = data;
            refresh_irq();
         end else if (!offset[0]) begin
            msb_buf_q = data;
         end else begin
            latch_q[t] = {msb_buf_q, data};
            if ((ctrl_q[t] & HOLD_LOAD_MASK) == 8'h00)
               count_q[t] = latch_q[t];
            status_q[t] = 1'b0;
            refresh_irq();
         end
      endfunction

      // one internal clock: returns the timers that timed out
      function logic [2:0] tick();
         logic [2:0] done;
         logic [7:0] c;
         int t;
         done = 3'b000;
         if (ctrl_q[0][0])
            return done;
         for (t = 0; t < NUM_TIMERS; t++) begin
            c = ctrl_q[t];
            if (!c[1] || c[3])
               continue;
            if (count_q[t] == 16'h0000) begin
               done[t] = 1'b1;
               status_q[t] = 1'b1;
               if ((c & IRQ_ENABLE_MASK) != 8'h00)
                  status_q[7] = 1'b1;
               count_q[t] = latch_q[t];
               if (t != 2)
                  continue;
            end else if (t != 2) begin
               count_q[t] = count_q[t] - 16'd1;
               continue;
            end
            // timer 3 counts in the reload tick too, optionally divided by 8
            if (c[0]) begin
               prescale_q = prescale_q + 3'd1;
               if (prescale_q == 3'd0)
                  count_q[2] = count_q[2] - 16'd1;
            end else begin
               count_q[2] = count_q[2] - 16'd1;
            end
         end
         return done;
      endfunction

      // external clock pulse for timer 1 (t = 0) or timer 2 (t = 1)
      function logic pulse(int t);
         logic run;
         if (t == 0)
            run = (ctrl_q[0][1:0] != 2'b11);
         else
            run = !ctrl_q[0][0] && !ctrl_q[1][1];
         if (!run || count_q[t] == 16'h0000)
            return 1'b0;
         count_q[t] = count_q[t] - 16'd1;
         if (count_q[t] != 16'h0000)
            return 1'b0;
         status_q[t] = 1'b1;
         if ((ctrl_q[t] & IRQ_ENABLE_MASK) != 8'h00) begin
            status_q[7] = 1'b1;
            seen_q = seen_q & ~status_q;
         end
         if (t == 0 || (ctrl_q[1] & MODE_MASK) == 8'h00)
            count_q[t] = latch_q[t];
         return 1'b1;
      endfunction

      // accepted request: advance the model and queue the result it owes
      function void note_item(ttpm_item_type item);
         ttpm_result_type r;
         r.read_data = 8'h00;
         r.done      = 3'b000;
         case (item.kind)
            KIND_READ:   r.read_data = bus_read(item.offset);
            KIND_WRITE:  bus_write(item.offset, item.write_data);
            KIND_TICK:   r.done = tick();
            KIND_PULSE1: r.done[0] = pulse(0);
            KIND_PULSE2: r.done[1] = pulse(1);
            default: ;
         endcase
         r.irq = status_q[7];
         awaited_results.push_back(r);
      endfunction

      // accepted result: compare with the oldest one owed
      function void check_result(ttpm_result_type got);
         ttpm_result_type want;
         int t;
         if (awaited_results.size() == 0) begin
            error_count++;
            $error("result transfer with no request outstanding");
            return;
         end
         want = awaited_results.pop_front();
         if (got.read_data !== want.read_data) begin
            error_count++;
            $error("read_data: expected %02h, got %02h", want.read_data, got.read_data);
         end
         if (got.irq !== want.irq) begin
            error_count++;
            $error("irq: expected %0b, got %0b", want.irq, got.irq);
         end
         for (t = 0; t < NUM_TIMERS; t++)
            if (got.done[t] !== want.done[t]) begin
               error_count++;
               $error("timer%0d_done: expected %0b, got %0b", t + 1, want.done[t],
                      got.done[t]);
            end
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction
   endclass

endpackage

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Testbench top: drives reads, writes, ticks and pulses into the three-timer module.
module tb;
   import ttpm_pkg::*;
   import ttpm_tb_pkg::*;

   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
   localparam int RANDOM_ITEMS = 450;
   localparam int STALL_AT     = 200;
   localparam int STALL_CYCLES = 80;

   logic clock = 1'b0;
   logic reset;

   ttpm_req_if req_bus ();
   ttpm_rsp_if rsp_bus ();

   three_timer_programmable_module_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   timer_scoreboard sb;
   int sent_count = 0;
   bit stall_done = 1'b0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // watch both channels; results first, then the new request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result({rsp_bus.read_data, rsp_bus.irq, rsp_bus.timer3_done,
                             rsp_bus.timer2_done, rsp_bus.timer1_done});
         if (req_bus.valid && req_bus.ready)
            sb.note_item({req_bus.kind, req_bus.offset, req_bus.write_data});
      end
   end

   // offer one item and hold it until the transfer
   task automatic offer(logic [2:0] kind, logic [2:0] offset, logic [7:0] data);
      int gap;
      gap = pick_gap();
      // no idling on the send side around the long receiver stall
      if (sent_count >= STALL_AT && sent_count < STALL_AT + 40)
         gap = 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= kind;
      req_bus.offset     <= offset;
      req_bus.write_data <= data;
      do @(posedge clock); while (!req_bus.ready);
      sent_count++;
   endtask

   // result side: random ready, plus one long hold-off
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!stall_done && sent_count >= STALL_AT) begin
            stall_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // stimulus
   initial begin
      int base;
      int n;
      int r;
      int t;
      logic [7:0] v;
      sb = new();
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.kind       <= KIND_READ;
      req_bus.offset     <= OFS_CTRL13;
      req_bus.write_data <= 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset state, unused kinds, a timer 1 pulse, blocked tick and timer 2 pulse
      offer(KIND_READ, OFS_CTRL13, 8'hFF);
      offer(KIND_READ, OFS_STATUS, 8'h00);
      offer(KIND_READ, 3'd2, 8'h00);
      offer(KIND_SPARE_FIRST, 3'd7, 8'hFF);
      offer(KIND_SPARE_LAST, 3'd0, 8'h00);
      offer(KIND_PULSE1, 3'd0, 8'h00);
      offer(KIND_PULSE2, 3'd0, 8'h00);
      offer(KIND_TICK, 3'd0, 8'h00);
      // timer 1 on the internal clock, reaches zero with interrupt enabled
      offer(KIND_WRITE, OFS_CTRL2, 8'h41);
      offer(KIND_WRITE, 3'd2, 8'h00);
      offer(KIND_WRITE, 3'd3, 8'h02);
      offer(KIND_WRITE, OFS_CTRL13, 8'h42);
      repeat (3) offer(KIND_TICK, 3'd0, 8'h00);
      // status read then MSB read clears the flag
      offer(KIND_READ, OFS_STATUS, 8'h00);
      offer(KIND_READ, 3'd2, 8'h00);
      // timer 2 external pulse times out and reloads
      offer(KIND_WRITE, 3'd4, 8'h00);
      offer(KIND_WRITE, 3'd5, 8'h01);
      offer(KIND_PULSE2, 3'd0, 8'h00);
      // timer 3 reload of zero wraps to all ones
      offer(KIND_WRITE, OFS_CTRL2, 8'h00);
      offer(KIND_WRITE, OFS_CTRL13, 8'h02);
      offer(KIND_WRITE, 3'd7, 8'h00);
      offer(KIND_TICK, 3'd0, 8'h00);
      // control 1 write with bit 0 clears status; timer 1 pulses held
      offer(KIND_WRITE, OFS_CTRL2, 8'h01);
      offer(KIND_WRITE, OFS_CTRL13, 8'hFF);
      offer(KIND_PULSE1, 3'd0, 8'h00);
      offer(KIND_READ, 3'd6, 8'h00);

      // random: program all timers with short counts, then run a burst
      base = sent_count;
      while (sent_count - base < RANDOM_ITEMS) begin
         // control 3 through offset 0 with control 2 bit 0 clear
         offer(KIND_WRITE, OFS_CTRL2, 8'h00);
         v = 8'($urandom);
         v[1] = ($urandom_range(0, 3) != 0);
         v[3] = ($urandom_range(0, 5) == 0);
         offer(KIND_WRITE, OFS_CTRL13, v);
         // control 2, then control 1
         v = 8'($urandom);
         v[0] = 1'b1;
         v[1] = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 7)
            v = v & ~MODE_MASK;
         offer(KIND_WRITE, OFS_CTRL2, v);
         v = 8'($urandom);
         v[0] = ($urandom_range(0, 9) == 0);
         v[1] = ($urandom_range(0, 3) != 0);
         v[3] = ($urandom_range(0, 5) == 0);
         offer(KIND_WRITE, OFS_CTRL13, v);
         // latches
         for (t = 0; t < NUM_TIMERS; t++) begin
            v = ($urandom_range(0, 9) < 8) ? 8'h00 : 8'($urandom);
            offer(KIND_WRITE, 3'(2 + 2 * t), v);
            v = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 12)) : 8'($urandom);
            offer(KIND_WRITE, 3'(3 + 2 * t), v);
         end
         // burst of mixed traffic
         n = $urandom_range(12, 30);
         repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 40)
               offer(KIND_TICK, 3'($urandom), 8'($urandom));
            else if (r < 50)
               offer(KIND_PULSE1, 3'($urandom), 8'($urandom));
            else if (r < 60)
               offer(KIND_PULSE2, 3'($urandom), 8'($urandom));
            else if (r < 70)
               offer(KIND_READ, 3'($urandom), 8'($urandom));
            else if (r < 80) begin
               offer(KIND_READ, OFS_STATUS, 8'($urandom));
               offer(KIND_READ, 3'(2 + 2 * $urandom_range(0, 2)), 8'($urandom));
            end else if (r < 95)
               offer(KIND_WRITE, 3'($urandom), 8'($urandom));
            else
               offer(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)), 3'($urandom),
                     8'($urandom));
         end
      end
      req_bus.valid <= 1'b0;

      // drain, then wait for stray results
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
